### rtl/pingpong_message_buffer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ping-pong message buffer
// Short wrappers around concurrent assertions, clocked on clk_i and held
// off while rst_ni is low. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PINGPONG_MESSAGE_BUFFER_UNIT_ASSERT_SVH
`define PINGPONG_MESSAGE_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge.
`define PMB_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pmb assertion failed");
// Condition that must hold in the cycle after a trigger.
`define PMB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pmb assertion failed");
`else
`define PMB_ASSERT(lbl, cond)
`define PMB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/pmb_pkg.sv
// ----------------------------------------------------------------------------
// pmb_pkg
// Shared constants, codes and types of the ping-pong message buffer.
// ----------------------------------------------------------------------------
package pmb_pkg;

  // Size of one bank in bytes.
  localparam int unsigned BANK_BYTES = 1024;
  // Width of fill, head and write position (must hold BANK_BYTES itself).
  localparam int unsigned PTR_W      = $clog2(BANK_BYTES + 1);
  // Width of a byte index inside one bank.
  localparam int unsigned ADDR_W     = $clog2(BANK_BYTES);
  // Width used for the capacity check of a new message.
  localparam int unsigned SUM_W      = PTR_W + 1;
  // Entries of the command queue between front and back (power of two).
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADLEN = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_SMALL  = 3'd4;
  localparam logic [2:0] ST_BUSY   = 3'd5;

  // Request type field values.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Command kinds as classified by the front end.
  typedef enum logic [1:0] {
    CMD_WR_FIRST = 2'd0,
    CMD_WR_NEXT  = 2'd1,
    CMD_READ     = 2'd2,
    CMD_BUSY     = 2'd3
  } cmd_kind_e;

  // One queued command.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data_byte;
    logic [7:0] msg_len;
    logic       last_byte;
    logic [7:0] read_capacity;
  } cmd_t;

endpackage

### rtl/pmb_if.sv
// ----------------------------------------------------------------------------
// pmb_req_if / pmb_rsp_if
// Valid/ready channels of the message buffer: requests in, results out.
// ----------------------------------------------------------------------------
interface pmb_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [7:0] msg_len;
  logic       last_byte;
  logic [7:0] read_capacity;

  modport source (output valid, req_type, data_byte, msg_len, last_byte,
                  read_capacity, input ready);
  modport sink   (input valid, req_type, data_byte, msg_len, last_byte,
                  read_capacity, output ready);
endinterface

interface pmb_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  beat_bytes;
  logic [7:0]  result_len;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, data_word, beat_bytes, result_len, status, last,
                  input ready);
  modport sink   (input valid, data_word, beat_bytes, result_len, status, last,
                  output ready);
endinterface

### rtl/pmb_front.sv
// ----------------------------------------------------------------------------
// pmb_front
// Accepts request items and classifies them by the open-message state into
// first write byte, further write byte, read, or read refused as busy.
// ----------------------------------------------------------------------------
module pmb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pmb_req_if.sink        req_i,
  output pmb_pkg::cmd_t  cmd_o,
  output logic           cmd_push_o,
  input  logic           cmd_full_i
);
  import pmb_pkg::*;

  logic open_q, open_d;
  logic accept;

  // An item is taken whenever the queue has room.
  assign req_i.ready = !cmd_full_i;
  assign accept      = req_i.valid && !cmd_full_i;
  assign cmd_push_o  = accept;

  // Classify the item against the open-message flag.
  always_comb begin
    cmd_o.data_byte     = req_i.data_byte;
    cmd_o.msg_len       = req_i.msg_len;
    cmd_o.last_byte     = req_i.last_byte;
    cmd_o.read_capacity = req_i.read_capacity;
    if (req_i.req_type == REQ_READ) begin
      cmd_o.kind = open_q ? CMD_BUSY : CMD_READ;
    end else begin
      cmd_o.kind = open_q ? CMD_WR_NEXT : CMD_WR_FIRST;
    end
  end

  // A message is open from its first byte until its final byte.
  always_comb begin
    open_d = open_q;
    if (accept && (req_i.req_type == REQ_WRITE)) begin
      open_d = !req_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

### rtl/pmb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pmb_cmd_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pmb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pmb_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pmb_pkg::cmd_t head_o,
  output logic          valid_o
);
  import pmb_pkg::*;

  cmd_t                 entries_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CMD_CNT_W'(1);
      end
    end
  end

endmodule

### rtl/pmb_back.sv
// ----------------------------------------------------------------------------
// pmb_back
// Executes queued commands against the two byte banks: stores message bytes
// with their length prefix, commits or drops messages, and streams read
// messages out in beats of up to eight bytes through an output register.
// ----------------------------------------------------------------------------
`include "pingpong_message_buffer_unit_assert.svh"

module pmb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pmb_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  pmb_rsp_if.source     rsp_o
);
  import pmb_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WRBYTE = 2'd1;
  localparam logic [1:0] S_RDLEN  = 2'd2;
  localparam logic [1:0] S_RDBYTE = 2'd3;

  localparam logic [PTR_W-1:0] FILL_MAX = PTR_W'(BANK_BYTES);

  // Byte store: both banks in one single-port-write, single-port-read array.
  logic [7:0]        bank_mem [2 * (2 ** ADDR_W)];
  logic [7:0]        rd_data_q;
  logic              mem_we, mem_re;
  logic [ADDR_W:0]   mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  // Control state.
  logic [1:0]        state_q, state_d;
  logic              sel_q, sel_d;
  logic [PTR_W-1:0]  fill_q [2];
  logic [PTR_W-1:0]  fill_d [2];
  logic [PTR_W-1:0]  head_q [2];
  logic [PTR_W-1:0]  head_d [2];
  logic              kept_q, kept_d;
  logic [PTR_W-1:0]  wr_pos_q, wr_pos_d;
  logic [8:0]        wr_cnt_q, wr_cnt_d;
  logic [7:0]        wr_len_q, wr_len_d;
  logic [2:0]        wr_code_q, wr_code_d;
  logic [7:0]        rd_len_q, rd_len_d;
  logic [7:0]        rd_idx_q, rd_idx_d;
  logic [63:0]       word_q, word_d;

  // Output register.
  logic              out_valid_q;
  logic [63:0]       out_word_q;
  logic [3:0]        out_bytes_q;
  logic [7:0]        out_len_q;
  logic [2:0]        out_status_q;
  logic              out_last_q;

  // Result produced this cycle.
  logic              emit;
  logic [63:0]       em_word;
  logic [3:0]        em_bytes;
  logic [7:0]        em_len;
  logic [2:0]        em_status;
  logic              em_last;

  // Helpers.
  logic              can_emit;
  logic              wb;
  logic              store;
  logic [PTR_W-1:0]  pos_nx;
  logic [8:0]        cnt_nx;
  logic              len_match;
  logic [2:0]        step_status;
  logic              do_step;
  logic [SUM_W-1:0]  fit_sum;
  logic              rd_empty, oth_empty;
  logic              rb;
  logic [8:0]        rd_off;
  logic [PTR_W-1:0]  rd_pos;
  logic [2:0]        lane;
  logic [63:0]       beat_word;
  logic              end_beat, is_last;
  logic [PTR_W-1:0]  new_head;

  assign can_emit = !out_valid_q || rsp_o.ready;
  assign wb       = ~sel_q;

  // Per-byte write step of the open message.
  assign store       = kept_q && (wr_cnt_q < {1'b0, wr_len_q});
  assign pos_nx      = wr_pos_q + PTR_W'(store);
  assign cnt_nx      = wr_cnt_q[8] ? wr_cnt_q : (wr_cnt_q + 9'd1);
  assign len_match   = (cnt_nx == {1'b0, wr_len_q});
  assign step_status = !kept_q ? wr_code_q :
                       (cmd_i.last_byte && !len_match) ? ST_BADLEN : ST_OK;
  assign do_step     = can_emit && (state_q == S_WRBYTE ||
                       (state_q == S_IDLE && cmd_valid_i && cmd_i.kind == CMD_WR_NEXT));

  // Capacity check of a new message against the write bank fill.
  assign fit_sum = {1'b0, fill_q[wb]} + SUM_W'(1) + SUM_W'(cmd_i.msg_len);

  // Read bank selection with swap when the read bank is empty.
  assign rd_empty  = (head_q[sel_q] >= fill_q[sel_q]);
  assign oth_empty = (head_q[~sel_q] >= fill_q[~sel_q]);
  assign rb        = rd_empty ? ~sel_q : sel_q;

  // Byte address of the next read: the first body byte after the length,
  // otherwise the byte after the one arriving now.
  assign rd_off = (state_q == S_RDLEN) ? 9'd1 : ({1'b0, rd_idx_q} + 9'd2);
  assign rd_pos = head_q[sel_q] + PTR_W'(rd_off);

  // Beat assembly.
  assign lane      = rd_idx_q[2:0];
  assign beat_word = word_q | (64'(rd_data_q) << {lane, 3'b000});
  assign is_last   = ((rd_idx_q + 8'd1) == rd_len_q);
  assign end_beat  = (lane == 3'd7) || is_last;
  assign new_head  = head_q[sel_q] + PTR_W'(1) + PTR_W'(rd_len_q);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    fill_d    = fill_q;
    head_d    = head_q;
    kept_d    = kept_q;
    wr_pos_d  = wr_pos_q;
    wr_cnt_d  = wr_cnt_q;
    wr_len_d  = wr_len_q;
    wr_code_d = wr_code_q;
    rd_len_d  = rd_len_q;
    rd_idx_d  = rd_idx_q;
    word_d    = word_q;
    mem_we    = 1'b0;
    mem_waddr = {wb, wr_pos_q[ADDR_W-1:0]};
    mem_wdata = cmd_i.data_byte;
    mem_re    = 1'b0;
    mem_raddr = {sel_q, rd_pos[ADDR_W-1:0]};
    emit      = 1'b0;
    em_word   = '0;
    em_bytes  = '0;
    em_len    = '0;
    em_status = ST_OK;
    em_last   = 1'b1;
    cmd_pop_o = 1'b0;

    // A write byte of the open message: store, count, commit on the end.
    if (do_step) begin
      mem_we    = store;
      wr_pos_d  = pos_nx;
      wr_cnt_d  = cnt_nx;
      emit      = 1'b1;
      em_status = step_status;
      if (cmd_i.last_byte) begin
        kept_d = 1'b0;
        if (kept_q && len_match) begin
          fill_d[wb] = pos_nx;
        end
      end
      cmd_pop_o = 1'b1;
      state_d   = S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.kind)
              // First byte: check length and space, lay down the prefix.
              CMD_WR_FIRST: begin
                wr_len_d = cmd_i.msg_len;
                wr_cnt_d = '0;
                if (cmd_i.msg_len == 8'd0) begin
                  kept_d    = 1'b0;
                  wr_code_d = ST_BADLEN;
                end else if (fit_sum > SUM_W'(BANK_BYTES)) begin
                  kept_d    = 1'b0;
                  wr_code_d = ST_FULL;
                end else begin
                  kept_d    = 1'b1;
                  wr_code_d = ST_OK;
                  mem_we    = 1'b1;
                  mem_waddr = {wb, fill_q[wb][ADDR_W-1:0]};
                  mem_wdata = cmd_i.msg_len;
                  wr_pos_d  = fill_q[wb] + PTR_W'(1);
                end
                state_d = S_WRBYTE;
              end
              // Further bytes are taken by the write step above.
              CMD_WR_NEXT: begin
              end
              // Read: swap if needed, then fetch the length prefix.
              CMD_READ: begin
                if (rd_empty && oth_empty) begin
                  if (can_emit) begin
                    sel_d     = ~sel_q;
                    emit      = 1'b1;
                    em_status = ST_EMPTY;
                    cmd_pop_o = 1'b1;
                  end
                end else begin
                  sel_d     = rb;
                  mem_re    = 1'b1;
                  mem_raddr = {rb, head_q[rb][ADDR_W-1:0]};
                  state_d   = S_RDLEN;
                end
              end
              CMD_BUSY: begin
                if (can_emit) begin
                  emit      = 1'b1;
                  em_status = ST_BUSY;
                  cmd_pop_o = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Waiting for the write step to be able to deliver its result.
        S_WRBYTE: begin
        end
        // Length prefix has arrived: refuse or start the byte stream.
        S_RDLEN: begin
          if (rd_data_q > cmd_i.read_capacity) begin
            if (can_emit) begin
              emit      = 1'b1;
              em_status = ST_SMALL;
              cmd_pop_o = 1'b1;
              state_d   = S_IDLE;
            end
          end else begin
            rd_len_d = rd_data_q;
            rd_idx_d = '0;
            word_d   = '0;
            mem_re   = 1'b1;
            state_d  = S_RDBYTE;
          end
        end
        // One message byte per cycle unless a finished beat waits on a stalled output; a beat every eight bytes.
        S_RDBYTE: begin
          if (!end_beat || can_emit) begin
            rd_idx_d = rd_idx_q + 8'd1;
            mem_re   = !is_last;
            if (end_beat) begin
              emit      = 1'b1;
              em_word   = beat_word;
              em_bytes  = {1'b0, lane} + 4'd1;
              em_len    = rd_len_q;
              em_status = ST_OK;
              em_last   = is_last;
              word_d    = '0;
            end else begin
              word_d = beat_word;
            end
            if (is_last) begin
              if (new_head >= fill_q[sel_q]) begin
                head_d[sel_q] = '0;
                fill_d[sel_q] = '0;
              end else begin
                head_d[sel_q] = new_head;
              end
              cmd_pop_o = 1'b1;
              state_d   = S_IDLE;
            end
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  // Byte store with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bank_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bank_mem[mem_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      kept_q      <= 1'b0;
      wr_code_q   <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      kept_q    <= kept_d;
      wr_code_q <= wr_code_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the message in flight and of the output.
  always_ff @(posedge clk_i) begin
    wr_pos_q <= wr_pos_d;
    wr_cnt_q <= wr_cnt_d;
    wr_len_q <= wr_len_d;
    rd_len_q <= rd_len_d;
    rd_idx_q <= rd_idx_d;
    word_q   <= word_d;
    if (emit) begin
      out_word_q   <= em_word;
      out_bytes_q  <= em_bytes;
      out_len_q    <= em_len;
      out_status_q <= em_status;
      out_last_q   <= em_last;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.data_word  = out_word_q;
  assign rsp_o.beat_bytes = out_bytes_q;
  assign rsp_o.result_len = out_len_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.last       = out_last_q;

  // Checks on the sequencer.
  `PMB_ASSERT(a_pop_needs_cmd, !cmd_pop_o || cmd_valid_i)
  `PMB_ASSERT(a_no_result_overwrite, !emit || !out_valid_q || rsp_o.ready)
  `PMB_ASSERT(a_fill_in_range, (fill_q[0] <= FILL_MAX) && (fill_q[1] <= FILL_MAX))
  `PMB_ASSERT(a_head_within_fill, (head_q[0] <= fill_q[0]) && (head_q[1] <= fill_q[1]))
  `PMB_ASSERT(a_rd_idx_in_len, (state_q != S_RDBYTE) || (rd_idx_q < rd_len_q))
  `PMB_ASSERT_NEXT(a_pop_returns_idle, cmd_pop_o, state_q == S_IDLE)

endmodule

### rtl/pingpong_message_buffer_unit.sv
// ----------------------------------------------------------------------------
// pingpong_message_buffer_unit
// Ping-pong pair of byte banks holding length-prefixed messages: message
// bytes are written in, and the oldest message is read back in 8-byte beats.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake     Item
//  req_i    in         valid/ready   one write byte or one read request
//  rsp_o    out        valid/ready   one result: beat, status, last flag
//
// The first byte of a message also lays down its length prefix before it is
// stored like any other write byte. A read first fetches the length prefix,
// then streams one message byte per cycle unless a finished beat waits on a
// stalled output, bounded by the single read port of the byte store.
// Reset clears bank fills, heads and bank selection; no clearing pass runs.
// A stalled output holds the back end, while the two-entry command queue
// keeps taking items until it fills.
// ----------------------------------------------------------------------------
module pingpong_message_buffer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmb_req_if.sink   req_i,
  pmb_rsp_if.source rsp_o
);
  import pmb_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_valid;

  // Front end: accept and classify.
  pmb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_o      (push_cmd),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  // Command queue between the two halves.
  pmb_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (push_cmd),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .head_o      (head_cmd),
    .valid_o     (cmd_valid)
  );

  // Back end: banks, sequencer and output register.
  pmb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

### sim/pmb_result_checker.sv
// ----------------------------------------------------------------------------
// pmb_result_checker
// Watches both channels of the ping-pong message buffer, keeps its own
// copy of the banks and pointers, predicts the results of each accepted
// request, and compares every accepted result against the oldest one owed.
// ----------------------------------------------------------------------------
module pmb_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmb_req_if         req_i,
  pmb_rsp_if         rsp_i,
  output int         fail_cnt_o,
  output int         pend_cnt_o,
  output int         rsp_cnt_o,
  output logic [5:0] status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pmb_pkg::*;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  beat_bytes;
    logic [7:0]  result_len;
    logic [2:0]  status;
    logic        last;
  } pmb_result_t;

  // Shadow copy of the two banks and their pointers.
  logic [7:0]  bank_mem [2][BANK_BYTES];
  int unsigned fill_q [2];
  int unsigned head_q [2];
  bit          rd_bank;

  // State of the message being written.
  bit          msg_open;
  bit          msg_kept;
  int unsigned wr_pos;
  int unsigned wr_count;
  int unsigned wr_len;
  logic [2:0]  drop_code;

  // Results owed by the block, oldest first.
  pmb_result_t owed_results [$];

  function automatic pmb_result_t make_result(input logic [63:0] word, input logic [3:0] nb,
                                              input logic [7:0] len, input logic [2:0] st,
                                              input logic fin);
    pmb_result_t r;
    r.data_word  = word;
    r.beat_bytes = nb;
    r.result_len = len;
    r.status     = st;
    r.last       = fin;
    return r;
  endfunction

  // One message byte: first-byte checks, storage and commit on the final byte.
  task automatic apply_write_byte(input logic [7:0] wr_data, input logic [7:0] len_v,
                                  input logic fin);
    int unsigned wb;
    logic [2:0]  st;
    wb = rd_bank ? 0 : 1;
    if (!msg_open) begin
      msg_open = 1'b1;
      wr_count = 0;
      wr_len   = len_v;
      if (len_v == 8'd0) begin
        msg_kept  = 1'b0;
        drop_code = ST_BADLEN;
      end else if (fill_q[wb] + 1 + len_v > BANK_BYTES) begin
        msg_kept  = 1'b0;
        drop_code = ST_FULL;
      end else begin
        msg_kept  = 1'b1;
        drop_code = ST_OK;
        bank_mem[wb][fill_q[wb]] = len_v;
        wr_pos = fill_q[wb] + 1;
      end
    end
    if (msg_kept) begin
      // Bytes past the announced length are not stored.
      if (wr_count < wr_len && wr_pos < BANK_BYTES) begin
        bank_mem[wb][wr_pos] = wr_data;
        wr_pos++;
      end
      if (wr_count < 256) wr_count++;
      st = ST_OK;
      if (fin) begin
        if (wr_count == wr_len) fill_q[wb] = wr_pos;
        else st = ST_BADLEN;
      end
    end else begin
      st = drop_code;
    end
    if (fin) begin
      msg_open = 1'b0;
      msg_kept = 1'b0;
    end
    owed_results.push_back(make_result(64'd0, 4'd0, 8'd0, st, 1'b1));
  endtask

  // One read request: busy, swap, empty, too small, or the beats of a message.
  task automatic apply_read_request(input logic [7:0] cap);
    int unsigned rb;
    int unsigned len_v;
    int unsigned hd;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    logic [63:0] word;
    if (msg_open) begin
      owed_results.push_back(make_result(64'd0, 4'd0, 8'd0, ST_BUSY, 1'b1));
      return;
    end
    rb = rd_bank;
    if (head_q[rb] >= fill_q[rb]) begin
      rd_bank = ~rd_bank;
      rb = rd_bank;
      if (head_q[rb] >= fill_q[rb]) begin
        owed_results.push_back(make_result(64'd0, 4'd0, 8'd0, ST_EMPTY, 1'b1));
        return;
      end
    end
    hd    = head_q[rb];
    len_v = bank_mem[rb][hd];
    if (len_v > cap) begin
      owed_results.push_back(make_result(64'd0, 4'd0, 8'd0, ST_SMALL, 1'b1));
      return;
    end
    for (i = 0; i < len_v; i += 8) begin
      word = 64'd0;
      n = (len_v - i < 8) ? (len_v - i) : 8;
      for (j = 0; j < n; j++) word[8*j +: 8] = bank_mem[rb][hd + 1 + i + j];
      owed_results.push_back(make_result(word, n[3:0], len_v[7:0], ST_OK, i + 8 >= len_v));
    end
    // A drained bank starts over from the bottom.
    head_q[rb] = hd + 1 + len_v;
    if (head_q[rb] >= fill_q[rb]) begin
      head_q[rb] = 0;
      fill_q[rb] = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt_o++;
    end
  endtask

  // Results are checked before requests are predicted: no request can be
  // answered at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin
    pmb_result_t exp_r;
    if (!rst_ni) begin
      fill_q        = '{0, 0};
      head_q        = '{0, 0};
      rd_bank       = 1'b0;
      msg_open      = 1'b0;
      msg_kept      = 1'b0;
      wr_pos        = 0;
      wr_count      = 0;
      wr_len        = 0;
      drop_code     = ST_OK;
      owed_results.delete();
      fail_cnt_o    = 0;
      rsp_cnt_o     = 0;
      status_seen_o = '0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        rsp_cnt_o++;
        if (rsp_i.status < 6) status_seen_o[rsp_i.status] = 1'b1;
        if (owed_results.size() == 0) begin
          $error("result arrived with nothing expected (status %0d)", rsp_i.status);
          fail_cnt_o++;
        end else begin
          exp_r = owed_results.pop_front();
          check_field("data_word", exp_r.data_word, rsp_i.data_word);
          check_field("beat_bytes", exp_r.beat_bytes, rsp_i.beat_bytes);
          check_field("result_len", exp_r.result_len, rsp_i.result_len);
          check_field("status", exp_r.status, rsp_i.status);
          check_field("last", exp_r.last, rsp_i.last);
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.req_type == REQ_WRITE)
          apply_write_byte(req_i.data_byte, req_i.msg_len, req_i.last_byte);
        else
          apply_read_request(req_i.read_capacity);
      end
    end
    pend_cnt_o = owed_results.size();
  end

endmodule

### sim/pingpong_message_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// pingpong_message_buffer_unit_tb
// Drives directed and random message writes and reads into the buffer,
// fills a bank to the brim, and stalls both channels at random; the
// result checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module pingpong_message_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int DRAIN_CYCLES  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pmb_req_if req_if ();
  pmb_rsp_if rsp_if ();

  int         fail_cnt;
  int         pend_cnt;
  int         rsp_cnt;
  logic [5:0] status_seen;

  int burst_left;
  int sent_cnt;
  int cycle_cnt;

  always #4 clk_i = ~clk_i;

  pingpong_message_buffer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pmb_result_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fail_cnt_o    (fail_cnt),
    .pend_cnt_o    (pend_cnt),
    .rsp_cnt_o     (rsp_cnt),
    .status_seen_o (status_seen)
  );

  // Offers one item, with a random gap at the start of each burst.
  task automatic send_item(input logic rt, input logic [7:0] db, input logic [7:0] ml,
                           input logic lb, input logic [7:0] cap);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= rt;
    req_if.data_byte     <= db;
    req_if.msg_len       <= ml;
    req_if.last_byte     <= lb;
    req_if.read_capacity <= cap;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_read(input logic [7:0] cap);
    send_item(REQ_READ, 8'($urandom), 8'($urandom), 1'($urandom), cap);
  endtask

  // Writes nbytes bytes of a message announcing len_field bytes; a read
  // slips in before byte busy_at when that index lies inside the message.
  task automatic send_message(input int len_field, input int nbytes, input int busy_at);
    int k;
    logic [7:0] ml;
    for (k = 0; k < nbytes; k++) begin
      if (k == busy_at && k > 0) send_read(8'($urandom));
      // Later bytes mostly repeat the length; sometimes they carry noise.
      ml = (k == 0 || $urandom_range(0, 3) != 0) ? 8'(len_field) : 8'($urandom);
      send_item(REQ_WRITE, 8'($urandom), ml, k == nbytes - 1, 8'($urandom));
    end
  endtask

  // The sender stops until every owed result has come back. It first waits
  // for a clock edge so that the checker has counted the item accepted last.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pend_cnt == 0);
    @(posedge clk_i);
  endtask

  // Mostly short messages, a few up to the longest.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(1, 16);
    if (r < 19) return $urandom_range(17, 64);
    return $urandom_range(65, 255);
  endfunction

  // Receiver: a long hold-off first, then a changing mix of stall patterns.
  initial begin
    int mode;
    int span;
    int k;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 23);
      span = $urandom_range(8, 64);
      if (mode == 0) begin
        rsp_if.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
      end else begin
        for (k = 0; k < span; k++) begin
          if (mode < 9) rsp_if.ready <= 1'b1;
          else if (mode < 17) rsp_if.ready <= 1'($urandom);
          else rsp_if.ready <= (k % 3 != 0);
          @(posedge clk_i);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL pingpong_message_buffer_unit");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    int choice;
    int len_v;
    int nb;
    int busy_at;
    int r;
    int k;
    int rand_start;
    logic [7:0] cap;
    burst_left           = 0;
    sent_cnt             = 0;
    cycle_cnt            = 0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_WRITE;
    req_if.data_byte     = 8'd0;
    req_if.msg_len       = 8'd0;
    req_if.last_byte     = 1'b0;
    req_if.read_capacity = 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty banks, zero length, capacity limits, busy read,
    // length mismatches both ways, a two-beat read and a final empty read.
    send_read(8'd255);
    send_item(REQ_WRITE, 8'h00, 8'd0, 1'b1, 8'h00);
    send_message(0, 2, -1);
    send_item(REQ_WRITE, 8'hFF, 8'd1, 1'b1, 8'hFF);
    send_read(8'd0);
    send_message(9, 9, 1);
    send_message(2, 3, -1);
    send_message(3, 1, -1);
    send_read(8'd255);
    send_read(8'd9);
    send_read(8'd255);
    wait_drained();

    // Fill the write bank with longest messages until it refuses one,
    // then read it back, first with one byte too little room.
    for (k = 0; k < 4; k++) send_message(255, 255, -1);
    send_message(1, 1, -1);
    send_message(5, 5, -1);
    send_read(8'd254);
    for (k = 0; k < 4; k++) send_read(8'd255);
    send_read(8'd255);
    wait_drained();

    // Random traffic: mostly well-formed messages and reads, some noise.
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        len_v = pick_len();
        busy_at = (len_v > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len_v - 1) : -1;
        send_message(len_v, len_v, busy_at);
      end else if (choice < 78) begin
        r = $urandom_range(0, 9);
        if (r < 6) cap = 8'd255;
        else if (r < 8) cap = 8'($urandom);
        else cap = 8'($urandom_range(0, 8));
        send_read(cap);
      end else if (choice < 90) begin
        r = $urandom_range(0, 2);
        if (r == 0) begin
          send_message(0, $urandom_range(1, 4), -1);
        end else if (r == 1) begin
          len_v = $urandom_range(2, 20);
          send_message(len_v, $urandom_range(1, len_v - 1), -1);
        end else begin
          len_v = $urandom_range(1, 16);
          nb = len_v + $urandom_range(1, 4);
          send_message(len_v, nb, -1);
        end
      end else if (choice < 95) begin
        nb = $urandom_range(2, 5);
        for (k = 0; k < nb; k++) send_read(8'd255);
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run sent %0d items (%0d random) and checked %0d results.",
             sent_cnt, sent_cnt - rand_start, rsp_cnt);
    $display("Status codes seen, one bit per code from busy down to ok: %b", status_seen);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("PASS pingpong_message_buffer_unit");
    end else begin
      $display("FAIL pingpong_message_buffer_unit");
    end
    $finish;
  end

endmodule
